// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the root solver.
// Needs nothing else; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define QRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/qrs_pkg.sv
// Shared constants, payload types and root class codes of the quadratic root solver.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 32;
   localparam int TOL_W     = 16;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int DISC_W    = PROD_W + 3;        // signed b*b - 4*a*c
   localparam int RAD_W     = DISC_W - 1;        // magnitude of the discriminant
   localparam int SQRT_W    = RAD_W / 2;         // one root bit per sqrt stage
   localparam int SREM_W    = SQRT_W + 3;
   localparam int NUM_W     = SQRT_W + 2;        // signed -b +/- sqrt
   localparam int DEN_W     = COEF_W + 1;        // 2*|a| or |b|
   localparam int DVD_W     = NUM_W - 1 + FRAC_BITS;
   localparam int DREM_W    = DEN_W + 1;
   localparam int RES_W     = DVD_W + 1;

   typedef enum logic [2:0] {
      CLS_LIN_NONE = 3'd0,
      CLS_NO_REAL  = 3'd1,
      CLS_LIN_ONE  = 3'd2,
      CLS_DOUBLE   = 3'd3,
      CLS_TWO      = 3'd4,
      CLS_INFINITE = 3'd5
   } root_class_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_square;
      logic signed [COEF_W-1:0] coef_linear;
      logic signed [COEF_W-1:0] coef_const;
   } req_type;

   typedef struct packed {
      root_class_type           root_class;
      logic signed [COEF_W-1:0] root_low;
      logic signed [COEF_W-1:0] root_high;
      logic                     overflow;
   } rsp_type;

   // Travels beside the square root: numerators before the root is added.
   typedef struct packed {
      root_class_type          cls;
      logic signed [NUM_W-1:0] base_low;
      logic signed [NUM_W-1:0] base_high;
      logic                    use_root;
      logic [DEN_W-1:0]        den;
      logic                    den_neg;
   } side_type;

   typedef struct packed {
      root_class_type          cls;
      logic signed [RES_W-1:0] root_low;
      logic signed [RES_W-1:0] root_high;
   } quot_type;

endpackage

// File: hdl/qrs_front.sv
// Front end of the solver: zero tests, products, discriminant and case selection.
// Four register stages; uses qrs_pkg.
module qrs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [qrs_pkg::TOL_W-1:0] tol,
   input  logic               in_valid,
   input  qrs_pkg::req_type   in_data,
   output logic               out_valid,
   output logic [qrs_pkg::RAD_W-1:0] out_rad,
   output qrs_pkg::side_type  out_side
);

   function automatic logic [qrs_pkg::COEF_W-1:0] mag_of(
      input logic signed [qrs_pkg::COEF_W-1:0] v);
      return v[qrs_pkg::COEF_W-1] ? ~v + 1'b1 : v;
   endfunction

   function automatic logic is_small(input logic signed [qrs_pkg::COEF_W-1:0] v,
                                     input logic [qrs_pkg::TOL_W-1:0] t);
      logic [qrs_pkg::COEF_W-1:0] m;
      m = mag_of(v);
      return (m == '0) || (m < qrs_pkg::COEF_W'(t));
   endfunction

   // stage 1: coefficients
   logic                              v1_ff;
   logic signed [qrs_pkg::COEF_W-1:0] a1_ff, b1_ff, c1_ff;

   // stage 2: products and zero flags
   logic                              v2_ff;
   logic signed [qrs_pkg::PROD_W-1:0] bb2_ff, ac2_ff, bb2_in, ac2_in;
   logic                              za2_ff, zb2_ff, zc2_ff;
   logic signed [qrs_pkg::COEF_W-1:0] a2_ff, b2_ff;

   // stage 3: discriminant
   logic                              v3_ff;
   logic signed [qrs_pkg::DISC_W-1:0] d3_ff, d3_in;
   logic                              za3_ff, zb3_ff, zc3_ff;
   logic signed [qrs_pkg::COEF_W-1:0] a3_ff, b3_ff, c3_ff;
   logic signed [qrs_pkg::COEF_W-1:0] c2_ff;

   // stage 4: case selection
   logic                              v4_ff;
   logic [qrs_pkg::RAD_W-1:0]         rad4_ff, rad4_in;
   qrs_pkg::side_type                 side4_ff, side4_in;

   logic signed [qrs_pkg::DISC_W-1:0] dabs;
   logic [qrs_pkg::RAD_W-1:0]         dmag;
   logic                              dneg, dsmall;
   logic [qrs_pkg::COEF_W-1:0]        amag, bmag;
   logic signed [qrs_pkg::NUM_W-1:0]  neg_b, neg_c;

   assign bb2_in = b1_ff * b1_ff;
   assign ac2_in = a1_ff * c1_ff;
   assign d3_in  = qrs_pkg::DISC_W'(bb2_ff) - (qrs_pkg::DISC_W'(ac2_ff) <<< 2);

   assign dneg   = d3_ff[qrs_pkg::DISC_W-1];
   assign dabs   = dneg ? -d3_ff : d3_ff;
   assign dmag   = dabs[qrs_pkg::RAD_W-1:0];
   assign dsmall = (dmag == '0) || (dmag < (qrs_pkg::RAD_W'(tol) << qrs_pkg::FRAC_BITS));
   assign amag   = mag_of(a3_ff);
   assign bmag   = mag_of(b3_ff);
   assign neg_b  = -qrs_pkg::NUM_W'(b3_ff);
   assign neg_c  = -qrs_pkg::NUM_W'(c3_ff);

   always_comb begin
      side4_in.cls       = qrs_pkg::CLS_LIN_NONE;
      side4_in.base_low  = '0;
      side4_in.base_high = '0;
      side4_in.use_root  = 1'b0;
      side4_in.den       = qrs_pkg::DEN_W'(1);
      side4_in.den_neg   = 1'b0;
      rad4_in            = '0;
      if (za3_ff) begin
         if (zb3_ff) begin
            side4_in.cls = zc3_ff ? qrs_pkg::CLS_INFINITE : qrs_pkg::CLS_LIN_NONE;
         end else begin
            side4_in.cls      = qrs_pkg::CLS_LIN_ONE;
            side4_in.base_low = zc3_ff ? '0 : neg_c;
            side4_in.den      = {1'b0, bmag};
            side4_in.den_neg  = b3_ff[qrs_pkg::COEF_W-1];
         end
      end else if (zc3_ff) begin
         if (zb3_ff) begin
            side4_in.cls = qrs_pkg::CLS_DOUBLE;
         end else begin
            // roots 0 and -b/a
            side4_in.cls       = qrs_pkg::CLS_TWO;
            side4_in.base_high = neg_b;
            side4_in.den       = {1'b0, amag};
            side4_in.den_neg   = a3_ff[qrs_pkg::COEF_W-1];
         end
      end else if (dsmall) begin
         side4_in.cls      = qrs_pkg::CLS_DOUBLE;
         side4_in.base_low = neg_b;
         side4_in.den      = {amag, 1'b0};
         side4_in.den_neg  = a3_ff[qrs_pkg::COEF_W-1];
      end else if (dneg) begin
         side4_in.cls = qrs_pkg::CLS_NO_REAL;
      end else begin
         side4_in.cls       = qrs_pkg::CLS_TWO;
         side4_in.base_low  = neg_b;
         side4_in.base_high = neg_b;
         side4_in.use_root  = 1'b1;
         side4_in.den       = {amag, 1'b0};
         side4_in.den_neg   = a3_ff[qrs_pkg::COEF_W-1];
         rad4_in            = dmag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff    <= in_data.coef_square;
         b1_ff    <= in_data.coef_linear;
         c1_ff    <= in_data.coef_const;
         bb2_ff   <= bb2_in;
         ac2_ff   <= ac2_in;
         za2_ff   <= is_small(a1_ff, tol);
         zb2_ff   <= is_small(b1_ff, tol);
         zc2_ff   <= is_small(c1_ff, tol);
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         c2_ff    <= c1_ff;
         d3_ff    <= d3_in;
         za3_ff   <= za2_ff;
         zb3_ff   <= zb2_ff;
         zc3_ff   <= zc2_ff;
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
         c3_ff    <= c2_ff;
         rad4_ff  <= rad4_in;
         side4_ff <= side4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rad   = rad4_ff;
   assign out_side  = side4_ff;

endmodule

// File: hdl/qrs_sqrt.sv
// Integer square root of the discriminant, one root bit per register stage.
// Carries the case sideband alongside; uses qrs_pkg.
module qrs_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [qrs_pkg::RAD_W-1:0]  in_rad,
   input  qrs_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [qrs_pkg::SQRT_W-1:0] out_root,
   output qrs_pkg::side_type          out_side
);

   localparam int N = qrs_pkg::SQRT_W;

   logic                       vld_ff  [N];
   logic [qrs_pkg::RAD_W-1:0]  rad_ff  [N];
   logic [qrs_pkg::SREM_W-1:0] rem_ff  [N];
   logic [qrs_pkg::SQRT_W-1:0] root_ff [N];
   qrs_pkg::side_type          side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                       vld_prev;
      logic [qrs_pkg::RAD_W-1:0]  rad_prev;
      logic [qrs_pkg::SREM_W-1:0] rem_prev, rem_sh, trial, rem_in;
      logic [qrs_pkg::SQRT_W-1:0] root_prev;
      qrs_pkg::side_type          side_prev;
      logic                       fits;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_prev[qrs_pkg::SREM_W-3:0],
                       rad_prev[qrs_pkg::RAD_W-1 -: 2]};
      assign trial  = qrs_pkg::SREM_W'({root_prev, 2'b01});
      assign fits   = rem_sh >= trial;
      assign rem_in = fits ? rem_sh - trial : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[k]  <= rad_prev << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_prev[qrs_pkg::SQRT_W-2:0], fits};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// File: hdl/qrs_div.sv
// Two-lane restoring divider sharing one divisor: both roots of one transaction.
// Numerator set-up stage, one quotient bit per stage, sign stage; uses qrs_pkg.
module qrs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [qrs_pkg::SQRT_W-1:0] in_root,
   input  qrs_pkg::side_type          in_side,
   output logic                       out_valid,
   output qrs_pkg::quot_type          out_quot
);

   localparam int N = qrs_pkg::DVD_W;

   // set-up stage: signed numerators
   logic                             pv_ff;
   logic signed [qrs_pkg::NUM_W-1:0] pn_ff [2];
   logic signed [qrs_pkg::NUM_W-1:0] pn_in [2];
   logic [qrs_pkg::DEN_W-1:0]        pden_ff;
   logic                             pdneg_ff;
   qrs_pkg::root_class_type          pcls_ff;
   logic signed [qrs_pkg::NUM_W-1:0] root_ext;

   // division stages
   logic                             vld_ff [N];
   logic [qrs_pkg::DEN_W-1:0]        den_ff [N];
   qrs_pkg::root_class_type          cls_ff [N];
   logic [qrs_pkg::DREM_W-1:0]       rem_ff [2][N];
   logic [qrs_pkg::DVD_W-1:0]        dq_ff  [2][N];
   logic                             neg_ff [2][N];

   // sign stage
   logic                             ov_ff;
   qrs_pkg::quot_type                quot_ff, quot_in;

   assign root_ext = in_side.use_root ? $signed(qrs_pkg::NUM_W'(in_root)) : '0;
   assign pn_in[0] = in_side.base_low + root_ext;
   assign pn_in[1] = in_side.base_high - root_ext;

   always_ff @(posedge clock) begin
      if (advance) begin
         pn_ff[0] <= pn_in[0];
         pn_ff[1] <= pn_in[1];
         pden_ff  <= in_side.den;
         pdneg_ff <= in_side.den_neg;
         pcls_ff  <= in_side.cls;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                      vld_prev;
      logic [qrs_pkg::DEN_W-1:0] den_prev;
      qrs_pkg::root_class_type   cls_prev;

      if (k == 0) begin : g_first
         assign vld_prev = pv_ff;
         assign den_prev = pden_ff;
         assign cls_prev = pcls_ff;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign cls_prev = cls_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k] <= den_prev;
            cls_ff[k] <= cls_prev;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [qrs_pkg::DREM_W-1:0] rem_prev, trial, rem_in;
         logic [qrs_pkg::DVD_W-1:0]  dq_prev;
         logic                       neg_prev, fits;

         if (k == 0) begin : g_first
            logic signed [qrs_pkg::NUM_W-1:0] nabs;
            assign nabs     = pn_ff[l][qrs_pkg::NUM_W-1] ? -pn_ff[l] : pn_ff[l];
            assign rem_prev = '0;
            assign dq_prev  = {nabs[qrs_pkg::NUM_W-2:0], {qrs_pkg::FRAC_BITS{1'b0}}};
            assign neg_prev = pn_ff[l][qrs_pkg::NUM_W-1] ^ pdneg_ff;
         end else begin : g_next
            assign rem_prev = rem_ff[l][k-1];
            assign dq_prev  = dq_ff[l][k-1];
            assign neg_prev = neg_ff[l][k-1];
         end

         // quotient bits fill the dividend register from the bottom
         assign trial  = {rem_prev[qrs_pkg::DREM_W-2:0], dq_prev[qrs_pkg::DVD_W-1]};
         assign fits   = trial >= qrs_pkg::DREM_W'(den_prev);
         assign rem_in = fits ? trial - qrs_pkg::DREM_W'(den_prev) : trial;

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[l][k] <= rem_in;
               dq_ff[l][k]  <= {dq_prev[qrs_pkg::DVD_W-2:0], fits};
               neg_ff[l][k] <= neg_prev;
            end
         end
      end
   end

   always_comb begin
      logic signed [qrs_pkg::RES_W-1:0] q_low, q_high;
      q_low            = $signed({1'b0, dq_ff[0][N-1]});
      q_high           = $signed({1'b0, dq_ff[1][N-1]});
      quot_in.cls       = cls_ff[N-1];
      quot_in.root_low  = neg_ff[0][N-1] ? -q_low : q_low;
      quot_in.root_high = neg_ff[1][N-1] ? -q_high : q_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (advance) begin
         pv_ff <= in_valid;
         ov_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_quot  = quot_ff;

endmodule

// File: hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: tolerance register, pipeline, ordering and clamping.
// Instantiates qrs_front, qrs_sqrt and qrs_div; uses qrs_pkg.
//
// Solves a*x^2 + b*x + c = 0 over signed Q16.16 coefficients and returns a class code
// with up to two real roots in ascending order, clamped to 32 bits with an overflow flag.
// Input channel req_*: one transaction carries a, b and c and is taken at a clock edge
// with req_valid high and req_stall low. Result channel rsp_*: one transaction per input,
// in order, taken at an edge with rsp_valid high and rsp_stall low.
// csr_wr_en/csr_wr_data write the 16-bit zero tolerance; write it only while idle.
// 90 register stages: 4 front-end stages (coefficients, products, discriminant, case
// selection), 33 square-root stages (one root bit each), 52 divider stages (set-up,
// 50 quotient bits, sign) and the output register.
// Throughput is one transaction per cycle while rsp_stall is low.
// A stalled result holds the whole pipeline; req_stall follows at once, nothing is lost.
// Synchronous reset empties the pipeline and sets the tolerance to 1.
module quadratic_root_solver (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  qrs_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output qrs_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [qrs_pkg::TOL_W-1:0] csr_wr_data
);

   function automatic logic [qrs_pkg::COEF_W:0] clamp(
      input logic signed [qrs_pkg::RES_W-1:0] v);
      logic [qrs_pkg::RES_W-qrs_pkg::COEF_W:0] top;
      top = v[qrs_pkg::RES_W-1:qrs_pkg::COEF_W-1];
      if ((&top) || !(|top)) begin
         return {1'b0, v[qrs_pkg::COEF_W-1:0]};
      end
      return v[qrs_pkg::RES_W-1] ? {1'b1, 1'b1, {(qrs_pkg::COEF_W-1){1'b0}}}
                                 : {1'b1, 1'b0, {(qrs_pkg::COEF_W-1){1'b1}}};
   endfunction

   logic [qrs_pkg::TOL_W-1:0]  tol_ff;
   logic                       advance;

   logic                       fe_valid;
   logic [qrs_pkg::RAD_W-1:0]  fe_rad;
   qrs_pkg::side_type          fe_side;
   logic                       sq_valid;
   logic [qrs_pkg::SQRT_W-1:0] sq_root;
   qrs_pkg::side_type          sq_side;
   logic                       dv_valid;
   qrs_pkg::quot_type          dv_quot;

   logic                       rsp_valid_ff;
   qrs_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= qrs_pkg::TOL_W'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tol       (tol_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fe_valid),
      .out_rad   (fe_rad),
      .out_side  (fe_side)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fe_valid),
      .in_rad    (fe_rad),
      .in_side   (fe_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot)
   );

   // order on the full-width values, then clamp each root
   always_comb begin
      logic signed [qrs_pkg::RES_W-1:0] lo, hi;
      logic [qrs_pkg::COEF_W:0]         lo_c, hi_c;
      lo = dv_quot.root_low;
      hi = dv_quot.root_high;
      if (dv_quot.cls == qrs_pkg::CLS_TWO && dv_quot.root_low > dv_quot.root_high) begin
         lo = dv_quot.root_high;
         hi = dv_quot.root_low;
      end
      lo_c                 = clamp(lo);
      hi_c                 = clamp(hi);
      rsp_data_in.root_class = dv_quot.cls;
      rsp_data_in.root_low   = $signed(lo_c[qrs_pkg::COEF_W-1:0]);
      rsp_data_in.root_high  = $signed(hi_c[qrs_pkg::COEF_W-1:0]);
      rsp_data_in.overflow   = lo_c[qrs_pkg::COEF_W] | hi_c[qrs_pkg::COEF_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/qrs_checker.sv
// Port-level checks of the quadratic root solver, bound to the top level.
// Uses qrs_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module qrs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qrs_pkg::rsp_type rsp_data
);

   `QRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result transaction changed")
   `QRS_ASSERT_NOW(a_stall_link, clock, reset, 1'b1,
      req_stall == (rsp_valid && rsp_stall), "input stall does not follow a held result")
   `QRS_ASSERT_NOW(a_high_only_two, clock, reset,
      rsp_valid && rsp_data.root_class != qrs_pkg::CLS_TWO,
      rsp_data.root_high == '0, "upper root set outside the two-root class")
   `QRS_ASSERT_NOW(a_two_ordered, clock, reset,
      rsp_valid && rsp_data.root_class == qrs_pkg::CLS_TWO,
      rsp_data.root_low <= rsp_data.root_high, "roots out of order")
   `QRS_ASSERT_NOW(a_no_root_clear, clock, reset,
      rsp_valid && (rsp_data.root_class == qrs_pkg::CLS_LIN_NONE ||
      rsp_data.root_class == qrs_pkg::CLS_NO_REAL ||
      rsp_data.root_class == qrs_pkg::CLS_INFINITE),
      rsp_data.root_low == '0 && !rsp_data.overflow, "root reported for a rootless class")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
